FILE: src/trb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trb_pkg;

  localparam int STAMP_W   = 32;
  localparam int CODE_W    = 16;
  localparam int SESSION_W = 32;
  localparam int ORD_W     = 6;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 6;

  // slots in the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE    = 4'd1;

  localparam logic              TRACE_ENABLE_RST = 1'b1;
  localparam logic [SIZE_W-1:0] RING_SIZE_RST    = 6'd32;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_DUMP   = 1'b1
  } req_kind_t;

  typedef enum logic {
    RES_HEADER = 1'b0,
    RES_ENTRY  = 1'b1
  } res_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MOD,
    BK_COUNT,
    BK_HEADER,
    BK_SCAN,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [STAMP_W-1:0]   stamp;
    logic [CODE_W-1:0]    event_code;
    logic [CODE_W-1:0]    return_code;
    logic [SESSION_W-1:0] session;
  } trace_entry_t;

  typedef struct packed {
    req_kind_t    kind;
    trace_entry_t entry;
  } trb_cmd_t;

  typedef struct packed {
    logic     valid;
    trb_cmd_t cmd;
  } trb_queue_head_t;

endpackage

`default_nettype wire

FILE: src/trb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module trb_front
  import trb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic                 req_type,
  input  wire logic [STAMP_W-1:0]   stamp,
  input  wire logic [CODE_W-1:0]    event_code,
  input  wire logic [CODE_W-1:0]    return_code,
  input  wire logic [SESSION_W-1:0] session,
  input  wire logic                 trace_enable,
  output trb_queue_head_t           head,
  input  wire logic                 pop
);

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  trb_cmd_t          slots [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QC_W-1:0]   fill;
  logic [QC_W-1:0]   fill_next;
  logic              accept;
  logic              push;
  trb_cmd_t          cmd_in;

  assign req_stall = (fill == QC_W'(QUEUE_DEPTH));
  assign accept    = req_valid && !req_stall;

  // records are dropped here while tracing is off
  assign push = accept && ((req_type == REQ_DUMP) || trace_enable);

  always_comb begin
    cmd_in.kind              = req_kind_t'(req_type);
    cmd_in.entry.stamp       = stamp;
    cmd_in.entry.event_code  = event_code;
    cmd_in.entry.return_code = return_code;
    cmd_in.entry.session     = session;
  end

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 1'b1;
    end else if (pop && !push) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  assign head.valid = (fill != '0);
  assign head.cmd   = slots[rd_ptr];

endmodule

`default_nettype wire

FILE: src/trb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module trb_back
  import trb_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  trb_queue_head_t                    head,
  output logic                               pop,
  input  wire logic [$clog2(DEPTH + 1)-1:0]  size,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic                               result_kind,
  output logic [ORD_W-1:0]                   ordinal,
  output logic [STAMP_W-1:0]                 out_stamp,
  output logic [CODE_W-1:0]                  out_event,
  output logic [CODE_W-1:0]                  out_return,
  output logic [SESSION_W-1:0]               out_session,
  output logic                               last_of_dump
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = $clog2(DEPTH + 1);

  trace_entry_t    mem [DEPTH];
  trace_entry_t    rd_data;
  logic            rd_en;
  logic [PW-1:0]   rd_addr;

  logic [DEPTH-1:0] filled;
  logic             wr_en;
  logic [PW-1:0]    wr_addr;

  back_state_t   state, state_next;
  logic [PW-1:0] wp, wp_next;
  logic [PW-1:0] idx, idx_next;
  logic [SW-1:0] start, start_next;
  logic [SW-1:0] rem, rem_next;
  logic [SW-1:0] count, count_next;
  logic [SW-1:0] n, n_next;

  logic             res_valid_next;
  res_kind_t        kind_q, kind_next;
  logic [ORD_W-1:0] ord_next;
  trace_entry_t     ent_q, ent_next;
  logic             last_next;

  logic          out_free;
  logic [PW-1:0] rec_idx;
  logic [SW-1:0] rec_inc;
  logic [SW-1:0] idx_inc;
  logic [PW-1:0] idx_adv;
  logic [SW-1:0] n_inc;

  assign out_free = !res_valid || !res_stall;

  // a pointer left beyond a shrunk ring sends the record to slot 0
  assign rec_idx = (SW'(wp) >= size) ? '0 : wp;
  assign rec_inc = SW'(rec_idx) + 1'b1;
  assign idx_inc = SW'(idx) + 1'b1;
  assign idx_adv = (idx_inc == size) ? '0 : PW'(idx_inc);
  assign n_inc   = n + 1'b1;

  always_comb begin
    state_next     = state;
    wp_next        = wp;
    idx_next       = idx;
    start_next     = start;
    rem_next       = rem;
    count_next     = count;
    n_next         = n;
    pop            = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = rec_idx;
    rd_en          = 1'b0;
    rd_addr        = idx;
    res_valid_next = res_valid && res_stall;
    kind_next      = kind_q;
    ord_next       = ordinal;
    ent_next       = ent_q;
    last_next      = last_of_dump;

    case (state)
      BK_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.cmd.kind == REQ_RECORD) begin
            wr_en   = 1'b1;
            wp_next = (rec_inc < size) ? PW'(rec_inc) : '0;
          end else begin
            start_next = SW'(wp);
            state_next = BK_MOD;
          end
        end
      end
      BK_MOD: begin
        // pointer modulo ring size by repeated subtraction
        if (start >= size) begin
          start_next = start - size;
        end else begin
          idx_next   = PW'(start);
          rem_next   = size;
          count_next = '0;
          state_next = BK_COUNT;
        end
      end
      BK_COUNT: begin
        count_next = count + SW'(filled[idx]);
        idx_next   = idx_adv;
        rem_next   = rem - 1'b1;
        if (rem == SW'(1)) begin
          state_next = BK_HEADER;
        end
      end
      BK_HEADER: begin
        if (out_free) begin
          res_valid_next = 1'b1;
          kind_next      = RES_HEADER;
          ord_next       = ORD_W'(count);
          ent_next       = '0;
          last_next      = (count == '0);
          idx_next       = PW'(start);
          n_next         = '0;
          state_next     = (count == '0) ? BK_IDLE : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (filled[idx]) begin
          rd_en      = 1'b1;
          state_next = BK_EMIT;
        end else begin
          idx_next = idx_adv;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          res_valid_next = 1'b1;
          kind_next      = RES_ENTRY;
          ord_next       = ORD_W'(n_inc);
          ent_next       = rd_data;
          last_next      = (n_inc == count);
          n_next         = n_inc;
          idx_next       = idx_adv;
          state_next     = (n_inc == count) ? BK_IDLE : BK_SCAN;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      wp        <= '0;
      filled    <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      res_valid <= res_valid_next;
      if (wr_en) begin
        filled[wr_addr] <= (head.cmd.entry.stamp != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx          <= idx_next;
    start        <= start_next;
    rem          <= rem_next;
    count        <= count_next;
    n            <= n_next;
    kind_q       <= kind_next;
    ordinal      <= ord_next;
    ent_q        <= ent_next;
    last_of_dump <= last_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= head.cmd.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign result_kind = kind_q;
  assign out_stamp   = ent_q.stamp;
  assign out_event   = ent_q.event_code;
  assign out_return  = ent_q.return_code;
  assign out_session = ent_q.session;

  a_ord_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN || state == BK_EMIT) |-> (n < count))
    else $error("entry number passed the header count");

  a_emit_filled: assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT) |-> (rd_data.stamp != '0))
    else $error("dump read an empty slot");

  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    (state == BK_HEADER && out_free && count == '0) |=> (state == BK_IDLE && last_of_dump))
    else $error("empty dump did not end on its header");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE) |-> ({1'b0, wp} < (PW + 1)'(DEPTH)))
    else $error("write pointer out of range");

endmodule

`default_nettype wire

FILE: src/trace_ring_buffer.sv
// channel | direction | transfer when          | payload
// req     | in        | req_valid & !req_stall | req_type, stamp, event_code, return_code, session
// res     | out       | res_valid & !res_stall | result_kind, ordinal, out_stamp, out_event,
//         |           |                        | out_return, out_session, last_of_dump
// cfg     | in        | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// Records retire one per cycle through a two-entry command queue while the back end is idle.
// A dump leaves the queue, reduces the pointer modulo the size by repeated subtraction (at most
// DEPTH-1 subtractions, none once the ring is steady), counts the filled flags of size slots,
// emits the header, then scans the slots up to the last filled one and emits each entry.
// Reset clears the filled flags; the entry memory itself is not cleared.
// A stall on res holds each header and entry; records queue behind a dump in order.
`timescale 1ns / 1ps
`default_nettype none

module trace_ring_buffer
  import trb_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic                 req_type,
  input  wire logic [STAMP_W-1:0]   stamp,
  input  wire logic [CODE_W-1:0]    event_code,
  input  wire logic [CODE_W-1:0]    return_code,
  input  wire logic [SESSION_W-1:0] session,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic                      result_kind,
  output logic [ORD_W-1:0]          ordinal,
  output logic [STAMP_W-1:0]        out_stamp,
  output logic [CODE_W-1:0]         out_event,
  output logic [CODE_W-1:0]         out_return,
  output logic [SESSION_W-1:0]      out_session,
  output logic                      last_of_dump,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int SW = $clog2(DEPTH + 1);

  logic              trace_enable;
  logic [SIZE_W-1:0] ring_size;
  logic [SW-1:0]     size;
  trb_queue_head_t   head;
  logic              pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_enable <= TRACE_ENABLE_RST;
      ring_size    <= RING_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRACE_ENABLE: trace_enable <= cfg_data[0];
        REG_RING_SIZE:    ring_size    <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero counts as one slot, anything past the built depth as the full depth
  always_comb begin
    if (ring_size == '0) begin
      size = SW'(1);
    end else if ({1'b0, ring_size} > (SIZE_W + 1)'(DEPTH)) begin
      size = SW'(DEPTH);
    end else begin
      size = SW'(ring_size);
    end
  end

  trb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .stamp        (stamp),
    .event_code   (event_code),
    .return_code  (return_code),
    .session      (session),
    .trace_enable (trace_enable),
    .head         (head),
    .pop          (pop)
  );

  trb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .size         (size),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_kind  (result_kind),
    .ordinal      (ordinal),
    .out_stamp    (out_stamp),
    .out_event    (out_event),
    .out_return   (out_return),
    .out_session  (out_session),
    .last_of_dump (last_of_dump)
  );

endmodule

`default_nettype wire
